// File: src/rtfe_pkg.sv
// ----------------------------------------------------------------------------
// rtfe_pkg: shared types and helpers for the record table filter engine
// Operation codes, controller states, command/status bundles, key matching.
// ----------------------------------------------------------------------------
package rtfe_pkg;

  localparam int DEPTH_DEF     = 32;
  localparam int KEY_CHARS_DEF = 8;
  localparam int MAX_HITS      = 32;
  localparam int KEY_W         = 64;
  localparam int NUM_W         = 31;
  localparam int RULE_W        = 4;
  localparam int SLOT_W        = 5;
  localparam int COUNT_W       = 6;
  localparam int EMIT_W        = $clog2(MAX_HITS + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SELECT = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch item, restart scan counters
    logic ins_write;  // append the item as a new record
    logic scan_run;   // step the scan pipeline
    logic load_done;  // load the completion item
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic scan_end;
    logic out_free;
  } stat_t;

  // Mask over the first n bytes of a key
  function automatic logic [KEY_W-1:0] byte_mask(input logic [RULE_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      m[8*b +: 8] = (b < int'(n)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Prefix compare; rule 0 accepts any key, rules past the key length compare it all
  function automatic logic key_match(input logic [KEY_W-1:0] stored,
                                     input logic [KEY_W-1:0] pattern,
                                     input logic [RULE_W-1:0] rule,
                                     input logic [RULE_W-1:0] key_chars);
    logic [RULE_W-1:0] n;
    n = (rule > key_chars) ? key_chars : rule;
    return (rule == '0) || (((stored ^ pattern) & byte_mask(n)) == '0);
  endfunction

endpackage

// File: src/rtfe_ctrl.sv
// ----------------------------------------------------------------------------
// rtfe_ctrl: sequencing of one item
// Accepts an item when idle, scans for non-inserts and issues the completion.
// ----------------------------------------------------------------------------
module rtfe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  logic [1:0]    op,
  output rtfe_pkg::cmd_t  cmd,
  input  rtfe_pkg::stat_t stat
);
  import rtfe_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   is_insert;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign is_insert  = (op_t'(op) == OP_INSERT);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through accept, scan (skipped on insert) and completion
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = is_insert ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.capture   = accept;
        cmd.ins_write = accept && is_insert && !stat.full;
      end
      ST_SCAN: cmd.scan_run  = 1'b1;
      ST_DONE: cmd.load_done = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/rtfe_dp.sv
// ----------------------------------------------------------------------------
// rtfe_dp: record storage, scan pipeline and result register
// One read per cycle bar stalls; matches updated, deleted, reported in order.
// ----------------------------------------------------------------------------
module rtfe_dp #(
  parameter int DEPTH     = rtfe_pkg::DEPTH_DEF,
  parameter int KEY_CHARS = rtfe_pkg::KEY_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rtfe_pkg::cmd_t                cmd,
  output rtfe_pkg::stat_t               stat,
  input  logic [1:0]                    op,
  input  logic [rtfe_pkg::KEY_W-1:0]    text1_pattern,
  input  logic [rtfe_pkg::RULE_W-1:0]   text1_rule,
  input  logic [rtfe_pkg::KEY_W-1:0]    text2_pattern,
  input  logic [rtfe_pkg::RULE_W-1:0]   text2_rule,
  input  logic [rtfe_pkg::NUM_W-1:0]    num_pattern,
  input  logic                          num_care,
  input  logic [rtfe_pkg::KEY_W-1:0]    new_text1,
  input  logic [rtfe_pkg::KEY_W-1:0]    new_text2,
  input  logic [rtfe_pkg::NUM_W-1:0]    new_num,
  input  logic [2:0]                    new_mask,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          kind,
  output logic [rtfe_pkg::SLOT_W-1:0]   slot,
  output logic [rtfe_pkg::KEY_W-1:0]    text1,
  output logic [rtfe_pkg::KEY_W-1:0]    text2,
  output logic [rtfe_pkg::NUM_W-1:0]    num,
  output logic [rtfe_pkg::COUNT_W-1:0]  count,
  output logic [rtfe_pkg::COUNT_W-1:0]  live_count,
  output logic                          last
);
  import rtfe_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
  localparam logic [RULE_W-1:0] KCH     = RULE_W'(KEY_CHARS);
  localparam logic [KEY_W-1:0]  KMASK   = byte_mask(RULE_W'(KEY_CHARS));

  // Record storage
  logic [KEY_W-1:0] t1_mem  [DEPTH];
  logic [KEY_W-1:0] t2_mem  [DEPTH];
  logic [NUM_W-1:0] num_mem [DEPTH];
  logic             del_mem [DEPTH];

  // Table counters
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] live_cnt;

  // Captured item
  op_t              op_r;
  logic [KEY_W-1:0] p_t1, p_t2, n_t1, n_t2;
  logic [RULE_W-1:0] r_t1, r_t2;
  logic [NUM_W-1:0] p_num, n_num;
  logic             care_r;
  logic [2:0]       mask_r;

  // Scan pipeline
  logic [CNT_W-1:0]  rd_idx;
  logic              s1_v;
  logic [IDX_W-1:0]  s1_idx;
  logic [KEY_W-1:0]  s1_t1, s1_t2;
  logic [NUM_W-1:0]  s1_num;
  logic              s1_del;
  logic [CNT_W-1:0]  hits;
  logic [EMIT_W-1:0] emit_cnt;

  logic             out_free, match, hit_emit, advance, issue, hit_take, modify;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_t1, wr_t2;
  logic [NUM_W-1:0] wr_num;
  logic             wr_del;

  // Compare the staged record and decide whether the stage can move
  always_comb begin
    out_free = !result_valid || result_ready;
    match    = s1_v && !s1_del
               && key_match(s1_t1, p_t1, r_t1, KCH)
               && key_match(s1_t2, p_t2, r_t2, KCH)
               && (!care_r || (s1_num == p_num));
    hit_emit = match && (emit_cnt < EMIT_W'(MAX_HITS));
    advance  = !(hit_emit && !out_free);
    issue    = cmd.scan_run && advance && (rd_idx != fill);
    hit_take = cmd.scan_run && match && advance;
    modify   = (op_r == OP_UPDATE) || (op_r == OP_DELETE);
  end

  // Select the write: append on insert, merge on update, flag on delete
  always_comb begin
    if (cmd.ins_write) begin
      wr_addr = fill[IDX_W-1:0];
      wr_t1   = text1_pattern & KMASK;
      wr_t2   = text2_pattern & KMASK;
      wr_num  = num_pattern;
      wr_del  = 1'b0;
    end else begin
      wr_addr = s1_idx;
      wr_t1   = (op_r == OP_UPDATE && mask_r[0]) ? (n_t1 & KMASK) : s1_t1;
      wr_t2   = (op_r == OP_UPDATE && mask_r[1]) ? (n_t2 & KMASK) : s1_t2;
      wr_num  = (op_r == OP_UPDATE && mask_r[2]) ? n_num : s1_num;
      wr_del  = (op_r == OP_DELETE);
    end
    wr_en = cmd.ins_write || (hit_take && modify);
  end

  // Write and read the record storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      t1_mem[wr_addr]  <= wr_t1;
      t2_mem[wr_addr]  <= wr_t2;
      num_mem[wr_addr] <= wr_num;
      del_mem[wr_addr] <= wr_del;
    end
    if (issue) begin
      s1_t1  <= t1_mem[rd_idx[IDX_W-1:0]];
      s1_t2  <= t2_mem[rd_idx[IDX_W-1:0]];
      s1_num <= num_mem[rd_idx[IDX_W-1:0]];
      s1_del <= del_mem[rd_idx[IDX_W-1:0]];
      s1_idx <= rd_idx[IDX_W-1:0];
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(op);
      p_t1   <= text1_pattern;
      r_t1   <= text1_rule;
      p_t2   <= text2_pattern;
      r_t2   <= text2_rule;
      p_num  <= num_pattern;
      care_r <= num_care;
      n_t1   <= new_text1;
      n_t2   <= new_text2;
      n_num  <= new_num;
      mask_r <= new_mask;
    end
  end

  // Advance counters and the scan stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      live_cnt <= '0;
      rd_idx   <= '0;
      s1_v     <= 1'b0;
      hits     <= '0;
      emit_cnt <= '0;
    end else begin
      if (cmd.capture) begin
        rd_idx   <= '0;
        s1_v     <= 1'b0;
        emit_cnt <= '0;
        hits     <= cmd.ins_write ? CNT_W'(1) : '0;
      end else if (cmd.scan_run && advance) begin
        s1_v <= issue;
        if (issue) rd_idx <= rd_idx + CNT_W'(1);
        if (hit_take) hits <= hits + CNT_W'(1);
        if (hit_take && hit_emit) emit_cnt <= emit_cnt + EMIT_W'(1);
      end
      if (cmd.ins_write) begin
        fill     <= fill + CNT_W'(1);
        live_cnt <= live_cnt + CNT_W'(1);
      end else if (hit_take && op_r == OP_DELETE) begin
        live_cnt <= live_cnt - CNT_W'(1);
      end
    end
  end

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((hit_take && hit_emit) || cmd.load_done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_take && hit_emit) begin
      kind       <= 1'b0;
      slot       <= SLOT_W'(s1_idx);
      text1      <= wr_t1;
      text2      <= wr_t2;
      num        <= wr_num;
      count      <= '0;
      live_count <= '0;
      last       <= 1'b0;
    end else if (cmd.load_done) begin
      kind       <= 1'b1;
      slot       <= '0;
      text1      <= '0;
      text2      <= '0;
      num        <= '0;
      count      <= COUNT_W'(hits);
      live_count <= COUNT_W'(live_cnt);
      last       <= 1'b1;
    end
  end

  assign stat.full     = (fill == DEPTH_C);
  assign stat.scan_end = (rd_idx == fill) && !s1_v;
  assign stat.out_free = out_free;

`ifndef SYNTHESIS
  a_live_le_fill: assert property (@(posedge clk) disable iff (rst)
    live_cnt <= fill) else $error("live count exceeds filled slots");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= EMIT_W'(MAX_HITS)) else $error("too many hit items emitted");

  a_stage_filled: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> (CNT_W'(s1_idx) < fill)) else $error("scan stage beyond filled slots");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("pending result item dropped");
`endif

endmodule

// File: src/record_table_filter_engine_unit.sv
// ----------------------------------------------------------------------------
// record_table_filter_engine_unit: append-only record table with filtered scan
// Top level joining the item controller and the storage datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_ready with op and the pattern fields; one
//   item is worked at a time and item_ready is high only while idle.
//   Insert appends a record unless the table is full and yields one
//   completion item once the output register is free, then goes idle.
//   Select, update and delete read the filled slots one per cycle, unless
//   the output stalls, from the record memory's single read port, emitting
//   one result item per match (up to MAX_HITS) in slot order, then a
//   completion item with the hit count and the live count.
//   Results leave on result_valid/result_ready from an output register; a
//   stalled receiver freezes the scan at the next match to be reported.
//   Reset clears the fill and live counts and the handshake state; stored
//   records need no clearing since only filled slots are ever read.
// ----------------------------------------------------------------------------
module record_table_filter_engine_unit #(
  parameter int DEPTH     = rtfe_pkg::DEPTH_DEF,
  parameter int KEY_CHARS = rtfe_pkg::KEY_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [1:0]                    op,
  input  logic [rtfe_pkg::KEY_W-1:0]    text1_pattern,
  input  logic [rtfe_pkg::RULE_W-1:0]   text1_rule,
  input  logic [rtfe_pkg::KEY_W-1:0]    text2_pattern,
  input  logic [rtfe_pkg::RULE_W-1:0]   text2_rule,
  input  logic [rtfe_pkg::NUM_W-1:0]    num_pattern,
  input  logic                          num_care,
  input  logic [rtfe_pkg::KEY_W-1:0]    new_text1,
  input  logic [rtfe_pkg::KEY_W-1:0]    new_text2,
  input  logic [rtfe_pkg::NUM_W-1:0]    new_num,
  input  logic [2:0]                    new_mask,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          kind,
  output logic [rtfe_pkg::SLOT_W-1:0]   slot,
  output logic [rtfe_pkg::KEY_W-1:0]    text1,
  output logic [rtfe_pkg::KEY_W-1:0]    text2,
  output logic [rtfe_pkg::NUM_W-1:0]    num,
  output logic [rtfe_pkg::COUNT_W-1:0]  count,
  output logic [rtfe_pkg::COUNT_W-1:0]  live_count,
  output logic                          last
);
  import rtfe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each item
  rtfe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .op         (op),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Store, scan and report
  rtfe_dp #(
    .DEPTH     (DEPTH),
    .KEY_CHARS (KEY_CHARS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .text1_pattern (text1_pattern),
    .text1_rule    (text1_rule),
    .text2_pattern (text2_pattern),
    .text2_rule    (text2_rule),
    .num_pattern   (num_pattern),
    .num_care      (num_care),
    .new_text1     (new_text1),
    .new_text2     (new_text2),
    .new_num       (new_num),
    .new_mask      (new_mask),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .kind          (kind),
    .slot          (slot),
    .text1         (text1),
    .text2         (text2),
    .num           (num),
    .count         (count),
    .live_count    (live_count),
    .last          (last)
  );

endmodule

// File: bench/record_table_filter_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_table_filter_engine_unit_tb: self-checking bench for the record table
// Drives insert, select, update and delete items over valid/ready, keeps a
// shadow copy of the table to predict every hit and completion item, and
// compares each result field by field under mixed sender and receiver stalls.
// ----------------------------------------------------------------------------
module record_table_filter_engine_unit_tb;
  import rtfe_pkg::*;

  localparam int TAB_DEPTH  = DEPTH_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int RAND_ITEMS = 445;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] text1_pattern;
    logic [3:0]       text1_rule;
    logic [KEY_W-1:0] text2_pattern;
    logic [3:0]       text2_rule;
    logic [NUM_W-1:0] num_pattern;
    logic             num_care;
    logic [KEY_W-1:0] new_text1;
    logic [KEY_W-1:0] new_text2;
    logic [NUM_W-1:0] new_num;
    logic [2:0]       new_mask;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   text1;
    logic [KEY_W-1:0]   text2;
    logic [NUM_W-1:0]   num;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] live;
    logic               last;
  } result_t;

  // Shadow table plus the queue of results it predicts
  class record_scoreboard;
    logic [KEY_W-1:0] t1_tab [TAB_DEPTH];
    logic [KEY_W-1:0] t2_tab [TAB_DEPTH];
    logic [NUM_W-1:0] n_tab  [TAB_DEPTH];
    bit               gone   [TAB_DEPTH];
    int               filled;
    result_t          pending[$];
    int               op_seen[4];
    int               full_inserts;
    int               checked;
    int               mismatches;

    function bit key_hit(logic [KEY_W-1:0] stored, logic [KEY_W-1:0] pat, logic [3:0] rule);
      int n;
      logic [KEY_W-1:0] m;
      n = (rule > 4'd8) ? 8 : int'(rule);
      if (n == 0) return 1'b1;
      m = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      return ((stored ^ pat) & m) == '0;
    endfunction

    function int live_total();
      int i;
      int live;
      live = 0;
      for (i = 0; i < filled; i++) begin
        if (!gone[i]) live++;
      end
      return live;
    endfunction

    function result_t summary(int hits);
      result_t r;
      r = '0;
      r.kind = 1'b1;
      r.count = COUNT_W'(hits);
      r.live = COUNT_W'(live_total());
      r.last = 1'b1;
      return r;
    endfunction

    // Append one predicted result at the tail of the queue
    function void queue_result(result_t r);
      pending.insert(pending.size(), r);
    endfunction

    // Apply one accepted item to the shadow table and queue its results
    function void note_item(item_t it);
      int i;
      int hits;
      int shown;
      result_t r;
      hits = 0;
      shown = 0;
      op_seen[int'(it.op)]++;
      if (it.op == OP_INSERT) begin
        if (filled < TAB_DEPTH) begin
          t1_tab[filled] = it.text1_pattern;
          t2_tab[filled] = it.text2_pattern;
          n_tab[filled] = it.num_pattern;
          gone[filled] = 1'b0;
          filled++;
          hits = 1;
        end else begin
          full_inserts++;
        end
        queue_result(summary(hits));
        return;
      end
      for (i = 0; i < filled; i++) begin
        if (gone[i]) continue;
        if (!key_hit(t1_tab[i], it.text1_pattern, it.text1_rule)) continue;
        if (!key_hit(t2_tab[i], it.text2_pattern, it.text2_rule)) continue;
        if (it.num_care && n_tab[i] != it.num_pattern) continue;
        if (it.op == OP_UPDATE) begin
          if (it.new_mask[0]) t1_tab[i] = it.new_text1;
          if (it.new_mask[1]) t2_tab[i] = it.new_text2;
          if (it.new_mask[2]) n_tab[i] = it.new_num;
        end else if (it.op == OP_DELETE) begin
          gone[i] = 1'b1;
        end
        hits++;
        if (shown < MAX_HITS) begin
          r = '0;
          r.slot = SLOT_W'(i);
          r.text1 = t1_tab[i];
          r.text2 = t2_tab[i];
          r.num = n_tab[i];
          queue_result(r);
          shown++;
        end
      end
      queue_result(summary(hits));
    endfunction

    // Compare one result item against the oldest prediction
    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d slot=%0d count=%0d live=%0d",
                   got.kind, got.slot, got.count, got.live);
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind || got.slot != want.slot || got.text1 != want.text1 ||
          got.text2 != want.text2 || got.num != want.num || got.count != want.count ||
          got.live != want.live || got.last != want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: kind=%0d slot=%0d t1=%h t2=%h num=%h cnt=%0d live=%0d last=%0d",
                   want.kind, want.slot, want.text1, want.text2, want.num, want.count,
                   want.live, want.last);
          $display("         got: kind=%0d slot=%0d t1=%h t2=%h num=%h cnt=%0d live=%0d last=%0d",
                   got.kind, got.slot, got.text1, got.text2, got.num, got.count,
                   got.live, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t drv;
  logic result_valid;
  logic result_ready;
  logic               kind;
  logic [SLOT_W-1:0]  slot;
  logic [KEY_W-1:0]   text1;
  logic [KEY_W-1:0]   text2;
  logic [NUM_W-1:0]   num;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] live_count;
  logic               last;

  record_scoreboard sb;
  int phase;
  int quiet;
  result_t seen;

  record_table_filter_engine_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .op            (drv.op),
    .text1_pattern (drv.text1_pattern),
    .text1_rule    (drv.text1_rule),
    .text2_pattern (drv.text2_pattern),
    .text2_rule    (drv.text2_rule),
    .num_pattern   (drv.num_pattern),
    .num_care      (drv.num_care),
    .new_text1     (drv.new_text1),
    .new_text2     (drv.new_text2),
    .new_num       (drv.new_num),
    .new_mask      (drv.new_mask),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .kind          (kind),
    .slot          (slot),
    .text1         (text1),
    .text2         (text2),
    .num           (num),
    .count         (count),
    .live_count    (live_count),
    .last          (last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Sender idles: phase 1 heavy, phase 3 light
  function automatic bit sender_idles();
    if (phase == 1) return $urandom_range(0, 99) < 82;
    if (phase == 3) return $urandom_range(0, 99) < 12;
    return 1'b0;
  endfunction

  // Stall the result channel per phase
  always @(negedge clk) begin
    if (phase == 2) result_ready = !($urandom_range(0, 99) < 82);
    else if (phase == 3) result_ready = !($urandom_range(0, 99) < 12);
    else result_ready = 1'b1;
  end

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.note_item(drv);
      if (result_valid && result_ready) begin
        seen.kind = kind;
        seen.slot = slot;
        seen.text1 = text1;
        seen.text2 = text2;
        seen.num = num;
        seen.count = count;
        seen.live = live_count;
        seen.last = last;
        sb.check_result(seen);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input item_t it);
    while (sender_idles()) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    drv = it;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  function automatic item_t mk(op_t o, logic [KEY_W-1:0] p1, logic [3:0] r1,
                               logic [KEY_W-1:0] p2, logic [3:0] r2,
                               logic [NUM_W-1:0] np, logic care,
                               logic [KEY_W-1:0] n1, logic [KEY_W-1:0] n2,
                               logic [NUM_W-1:0] nn, logic [2:0] m);
    item_t it;
    it.op = o;
    it.text1_pattern = p1;
    it.text1_rule = r1;
    it.text2_pattern = p2;
    it.text2_rule = r2;
    it.num_pattern = np;
    it.num_care = care;
    it.new_text1 = n1;
    it.new_text2 = n2;
    it.new_num = nn;
    it.new_mask = m;
    return it;
  endfunction

  // Short keys over a tiny alphabet so prefixes collide; some fully random
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    int len;
    int b;
    if ($urandom_range(0, 4) == 0) return {$urandom(), $urandom()};
    k = '0;
    len = $urandom_range(0, 8);
    for (b = 0; b < len; b++) k[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 2));
    return k;
  endfunction

  function automatic logic [NUM_W-1:0] rand_num();
    int x;
    x = $urandom_range(0, 9);
    if (x < 7) return NUM_W'($urandom_range(0, 3));
    if (x < 9) return NUM_W'($urandom());
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  function automatic logic [3:0] rand_rule();
    int x;
    x = $urandom_range(0, 99);
    if (x < 30) return 4'd0;
    if (x < 90) return 4'($urandom_range(1, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  // Random item; scan patterns lean on keys already in the table
  function automatic item_t build_item(op_t o, bit aimed);
    item_t it;
    int k;
    it = mk(o, {$urandom(), $urandom()}, 4'($urandom()), {$urandom(), $urandom()},
            4'($urandom()), NUM_W'($urandom()), 1'($urandom()), rand_key(), rand_key(),
            rand_num(), 3'($urandom()));
    k = (sb.filled > 0) ? $urandom_range(0, sb.filled - 1) : 0;
    if (o == OP_INSERT) begin
      it.text1_pattern = rand_key();
      it.text2_pattern = rand_key();
      it.num_pattern = rand_num();
    end else if (aimed && sb.filled > 0) begin
      it.text1_pattern = sb.t1_tab[k];
      it.text2_pattern = sb.t2_tab[k];
      it.num_pattern = sb.n_tab[k];
      it.text1_rule = 4'd8;
      it.text2_rule = 4'd8;
      it.num_care = 1'b1;
    end else begin
      it.text1_pattern = (sb.filled > 0 && $urandom_range(0, 99) < 60) ? sb.t1_tab[k]
                                                                        : rand_key();
      it.text2_pattern = (sb.filled > 0 && $urandom_range(0, 99) < 60) ? sb.t2_tab[k]
                                                                        : rand_key();
      it.num_pattern = (sb.filled > 0 && $urandom_range(0, 1)) ? sb.n_tab[k] : rand_num();
      it.text1_rule = rand_rule();
      it.text2_rule = rand_rule();
    end
    return it;
  endfunction

  localparam logic [KEY_W-1:0] K_AB  = 64'h6261;
  localparam logic [KEY_W-1:0] K_ABC = 64'h636261;
  localparam logic [KEY_W-1:0] K_ABD = 64'h646261;
  localparam logic [KEY_W-1:0] K_B   = 64'h62;
  localparam logic [KEY_W-1:0] K_ZZ  = 64'h7a7a;
  localparam logic [KEY_W-1:0] K_ONE = '1;
  localparam logic [NUM_W-1:0] N_TOP = '1;

  initial begin
    int n;
    int x;
    sb = new;
    phase = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    drv = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Scans on an empty table
    send_item(mk(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0));
    send_item(mk(OP_UPDATE, 0, 0, 0, 0, 0, 0, K_ONE, K_ONE, N_TOP, 3'd7));
    send_item(mk(OP_DELETE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0));
    // Extreme records and prefix-sharing keys
    send_item(mk(OP_INSERT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0));
    send_item(mk(OP_INSERT, K_ONE, 4'hF, K_ONE, 4'hF, N_TOP, 1, K_ONE, K_ONE, N_TOP, 3'd7));
    send_item(mk(OP_INSERT, K_AB, 0, K_ABC, 0, 5, 0, 0, 0, 0, 3'd0));
    send_item(mk(OP_INSERT, K_ABD, 0, K_B, 0, 5, 0, 0, 0, 0, 3'd0));
    // Selects over each kind of predicate, rule past the key length included
    send_item(mk(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0));
    send_item(mk(OP_SELECT, K_AB, 2, 0, 0, 0, 0, 0, 0, 0, 3'd0));
    send_item(mk(OP_SELECT, 0, 0, K_ABC, 8, 0, 0, 0, 0, 0, 3'd0));
    send_item(mk(OP_SELECT, 0, 0, K_ABC, 4'hF, 0, 0, 0, 0, 0, 3'd0));
    send_item(mk(OP_SELECT, 0, 0, 0, 0, 5, 1, 0, 0, 0, 3'd0));
    send_item(mk(OP_SELECT, K_ONE, 8, 0, 0, N_TOP, 1, 0, 0, 0, 3'd0));
    // Updates with each enable bit
    send_item(mk(OP_UPDATE, 64'h61, 1, 0, 0, 5, 1, K_ONE, K_ONE, N_TOP, 3'd0));
    send_item(mk(OP_UPDATE, 0, 0, 0, 0, 5, 1, K_ZZ, 0, 0, 3'd1));
    send_item(mk(OP_UPDATE, K_ZZ, 2, 0, 0, 0, 0, 0, 0, 0, 3'd2));
    send_item(mk(OP_UPDATE, 0, 0, 0, 8, 0, 0, 0, 0, 9, 3'd4));
    // Delete one record, then see it skipped and not deleted twice
    send_item(mk(OP_DELETE, K_ONE, 8, K_ONE, 8, N_TOP, 1, 0, 0, 0, 3'd0));
    send_item(mk(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0));
    send_item(mk(OP_DELETE, K_ONE, 8, K_ONE, 8, N_TOP, 1, 0, 0, 0, 3'd0));
    send_item(mk(OP_UPDATE, K_ZZ, 8, 0, 0, 0, 0, K_ABC, K_AB, 3, 3'd7));
    send_item(mk(OP_SELECT, K_ABC, 3, K_AB, 3, 0, 0, 0, 0, 0, 3'd0));

    // Random traffic, rotating the stall mix every 30 items
    for (n = 0; n < RAND_ITEMS; n++) begin
      phase = (n / 30) % 4;
      x = $urandom_range(0, 99);
      if (x < 25) send_item(build_item(OP_INSERT, 1'b0));
      else if (x < 57) send_item(build_item(OP_SELECT, $urandom_range(0, 9) == 0));
      else if (x < 90) send_item(build_item(OP_UPDATE, $urandom_range(0, 4) == 0));
      else send_item(build_item(OP_DELETE, $urandom_range(0, 2) == 0));
    end

    // Fill the table, then push inserts at a full table
    phase = 0;
    while (sb.filled < TAB_DEPTH) send_item(build_item(OP_INSERT, 1'b0));
    send_item(build_item(OP_INSERT, 1'b0));
    send_item(build_item(OP_INSERT, 1'b0));
    send_item(mk(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0));
    item_valid = 1'b0;

    // Drain, then hold idle before the summary
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d items: %0d insert (%0d at a full table), %0d select, %0d update, %0d delete",
             sb.op_seen[0] + sb.op_seen[1] + sb.op_seen[2] + sb.op_seen[3], sb.op_seen[0],
             sb.full_inserts, sb.op_seen[1], sb.op_seen[2], sb.op_seen[3]);
    $display("Checked %0d result items over four stall mixes; %0d mismatches, %0d outstanding",
             sb.checked, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
